// ===== design/ltmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltmc_pkg
// Shared types and constants of the luminance tint mask compositor.
// ----------------------------------------------------------------------------
package ltmc_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned LUM_W    = 15;  // 30r+59g+11b tops out at 25500
  localparam int unsigned DEN_W    = 18;  // 2*100*brightness
  localparam int unsigned NUM_W    = 24;  // largest rounded numerator
  localparam int unsigned DIVX_W   = 32;  // room for the shifted divisor
  localparam int unsigned NTINT    = 3;
  localparam int unsigned NDIV     = 9;   // three tints, three channels each
  localparam int unsigned DSTG     = 4;   // two quotient bits per stage
  localparam int unsigned NSTG     = 9;
  localparam int unsigned BRIGHT_W = 10;
  localparam logic [BRIGHT_W-1:0] BrightMax = 10'd1000;

  typedef enum logic [2:0] {
    CFG_COLOR_ONE    = 3'd0,
    CFG_COLOR_TWO    = 3'd1,
    CFG_GLOW         = 3'd2,
    CFG_BRIGHTNESS   = 3'd3,
    CFG_GLOW_REPLACE = 3'd4,
    CFG_MASK_ENABLE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [0:2][7:0] rgb;   // red, green, blue
    logic [7:0]      a;
    logic [0:2][7:0] m;     // color one, color two, glow
  } pix_t;

endpackage

// ===== design/luminance_tint_mask_compositor_unit.sv =====
// ----------------------------------------------------------------------------
// luminance_tint_mask_compositor_unit
// Recolors one RGBA pixel per beat under three tint masks.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, so a stream runs at one pixel per cycle while the
// output is not stalled. The stages are: luminance, divider operand setup,
// four stages of a restoring divider (two quotient bits each, nine dividers in
// parallel for three tints by three channels), then one blend stage per mask
// in the order color one, color two, glow. A stalled output holds the whole
// pipeline; in_ready_o follows out_ready_i in the same cycle. Configuration
// writes are always taken and must only happen while the pipeline is empty.
module luminance_tint_mask_compositor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  src_r_i,
  input  logic [7:0]  src_g_i,
  input  logic [7:0]  src_b_i,
  input  logic [7:0]  src_a_i,
  input  logic [7:0]  mask_one_i,
  input  logic [7:0]  mask_two_i,
  input  logic [7:0]  mask_glow_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_r_o,
  output logic [7:0]  out_g_o,
  output logic [7:0]  out_b_o,
  output logic [7:0]  out_a_o
);

  localparam int unsigned NumW  = ltmc_pkg::NUM_W;
  localparam int unsigned DenW  = ltmc_pkg::DEN_W;
  localparam int unsigned DivxW = ltmc_pkg::DIVX_W;

  // configuration
  logic [23:0] color_q [ltmc_pkg::NTINT];
  logic [ltmc_pkg::BRIGHT_W-1:0] bright_q;
  logic        replace_q;
  logic [2:0]  men_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ltmc_pkg::NTINT; i++) color_q[i] <= 24'hFFFFFF;
      bright_q  <= 10'd255;
      replace_q <= 1'b0;
      men_q     <= 3'd7;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ltmc_pkg::CFG_COLOR_ONE:    color_q[0] <= cfg_data_i;
        ltmc_pkg::CFG_COLOR_TWO:    color_q[1] <= cfg_data_i;
        ltmc_pkg::CFG_GLOW:         color_q[2] <= cfg_data_i;
        ltmc_pkg::CFG_BRIGHTNESS:   bright_q   <= cfg_data_i[9:0];
        ltmc_pkg::CFG_GLOW_REPLACE: replace_q  <= cfg_data_i[0];
        ltmc_pkg::CFG_MASK_ENABLE:  men_q      <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // clamped brightness times 100
  logic [ltmc_pkg::BRIGHT_W-1:0] bcl;
  logic [16:0] dval;
  logic [24:0] dlim;
  always_comb begin
    bcl = bright_q;
    if (bright_q == '0) bcl = 10'd1;
    if (bright_q > ltmc_pkg::BrightMax) bcl = ltmc_pkg::BrightMax;
    dval = 17'(bcl) * 17'd100;
    dlim = 25'(dval) * 25'd255;
  end

  // pipeline control
  logic       en;
  logic [ltmc_pkg::NSTG-1:0] valid_q;
  ltmc_pkg::pix_t pix_q [ltmc_pkg::NSTG];

  assign en          = !valid_q[ltmc_pkg::NSTG-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[ltmc_pkg::NSTG-1];
  assign out_r_o     = pix_q[ltmc_pkg::NSTG-1].rgb[0];
  assign out_g_o     = pix_q[ltmc_pkg::NSTG-1].rgb[1];
  assign out_b_o     = pix_q[ltmc_pkg::NSTG-1].rgb[2];
  assign out_a_o     = pix_q[ltmc_pkg::NSTG-1].a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[ltmc_pkg::NSTG-2:0], in_valid_i};
    end
  end

  // stage 1: capture and luminance
  ltmc_pkg::pix_t pix_in;
  logic [ltmc_pkg::LUM_W-1:0] lum_d, lum_q;
  always_comb begin
    pix_in.rgb = {src_r_i, src_g_i, src_b_i};
    pix_in.a   = src_a_i;
    pix_in.m   = {mask_one_i, mask_two_i, mask_glow_i};
    lum_d = 15'(src_r_i) * 15'd30 + 15'(src_g_i) * 15'd59 + 15'(src_b_i) * 15'd11;
  end

  // stage 2: divider operands, saturating branch keeps the hue
  logic [NumW-1:0] num_d [ltmc_pkg::NDIV];
  logic [DenW-1:0] den_d [ltmc_pkg::NDIV];
  logic [NumW-1:0] num_q [ltmc_pkg::NDIV];
  logic [DenW-1:0] den_q [ltmc_pkg::NDIV];
  always_comb begin
    logic [7:0] c, tmax;
    logic       sat;
    for (int i = 0; i < ltmc_pkg::NTINT; i++) begin
      tmax = color_q[i][23:16];
      if (color_q[i][15:8] > tmax) tmax = color_q[i][15:8];
      if (color_q[i][7:0] > tmax) tmax = color_q[i][7:0];
      sat = (25'(tmax) * 25'(lum_q)) > dlim;
      for (int j = 0; j < 3; j++) begin
        c = color_q[i][23-8*j -: 8];
        if (sat) begin
          num_d[i*3+j] = NumW'(c) * NumW'(510) + NumW'(tmax);
          den_d[i*3+j] = DenW'({tmax, 1'b0});
        end else begin
          num_d[i*3+j] = NumW'(c) * NumW'(lum_q) * NumW'(2) + NumW'(dval);
          den_d[i*3+j] = DenW'({dval, 1'b0});
        end
      end
    end
  end

  // stages 3..6: restoring divide, quotient fits in 8 bits
  logic [NumW-1:0] rem_d [ltmc_pkg::DSTG][ltmc_pkg::NDIV];
  logic [7:0]      quo_d [ltmc_pkg::DSTG][ltmc_pkg::NDIV];
  logic [NumW-1:0] rem_q [ltmc_pkg::DSTG][ltmc_pkg::NDIV];
  logic [7:0]      quo_q [ltmc_pkg::DSTG][ltmc_pkg::NDIV];
  logic [DenW-1:0] dv_q  [ltmc_pkg::DSTG][ltmc_pkg::NDIV];
  always_comb begin
    logic [DivxW-1:0] r, sh;
    logic [7:0]       q;
    logic [DenW-1:0]  dn;
    for (int s = 0; s < ltmc_pkg::DSTG; s++) begin
      for (int n = 0; n < ltmc_pkg::NDIV; n++) begin
        if (s == 0) begin
          r  = DivxW'(num_q[n]);
          q  = '0;
          dn = den_q[n];
        end else begin
          r  = DivxW'(rem_q[s-1][n]);
          q  = quo_q[s-1][n];
          dn = dv_q[s-1][n];
        end
        for (int k = 0; k < 2; k++) begin
          sh = DivxW'(dn) << (7 - 2*s - k);
          if (r >= sh) begin
            r = r - sh;
            q[7-2*s-k] = 1'b1;
          end
        end
        rem_d[s][n] = r[NumW-1:0];
        quo_d[s][n] = q;
      end
    end
  end

  // stages 7..9: blends; tints ride along for the later masks
  logic [7:0] tq_q [2][ltmc_pkg::NDIV];
  ltmc_pkg::pix_t bl_d [ltmc_pkg::NTINT];
  always_comb begin
    logic [7:0]  t, m;
    logic [15:0] y, sum;
    logic        app;
    for (int k = 0; k < ltmc_pkg::NTINT; k++) begin
      bl_d[k] = pix_q[5+k];
      m   = pix_q[5+k].m[k];
      app = men_q[k] && (m != 8'd0) && (pix_q[5+k].a != 8'd0);
      for (int j = 0; j < 3; j++) begin
        if (k == 0) t = quo_q[ltmc_pkg::DSTG-1][k*3+j];
        else        t = tq_q[k-1][k*3+j];
        y   = 16'(t) * 16'(m) + 16'(pix_q[5+k].rgb[j]) * 16'(8'd255 - m) + 16'd127;
        sum = y + (y >> 8) + 16'd1;   // exact divide by 255 in this range
        if (app) begin
          if (k == 2 && replace_q) bl_d[k].rgb[j] = t;
          else                     bl_d[k].rgb[j] = sum[15:8];
        end
      end
      if (app && m > pix_q[5+k].a) bl_d[k].a = m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q[0] <= pix_in;
      lum_q    <= lum_d;
      pix_q[1] <= pix_q[0];
      num_q    <= num_d;
      den_q    <= den_d;
      dv_q[0]  <= den_q;
      for (int s = 1; s < ltmc_pkg::DSTG; s++) dv_q[s] <= dv_q[s-1];
      for (int s = 0; s < ltmc_pkg::DSTG; s++) begin
        pix_q[2+s] <= pix_q[1+s];
        rem_q[s]   <= rem_d[s];
        quo_q[s]   <= quo_d[s];
      end
      tq_q[0] <= quo_q[ltmc_pkg::DSTG-1];
      tq_q[1] <= tq_q[0];
      for (int k = 0; k < ltmc_pkg::NTINT; k++) pix_q[6+k] <= bl_d[k];
    end
  end

endmodule

// ===== tb/tb_luminance_tint_mask_compositor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_luminance_tint_mask_compositor_unit
// Streams RGBA pixels with mask bytes through the compositor under random
// idling on both channels, across several register settings, and checks every
// output beat against a cycle-free predictor of the tint and blend math.
// ----------------------------------------------------------------------------
module tb_luminance_tint_mask_compositor_unit;

  typedef struct {
    logic [7:0] r, g, b, a;
  } rgba_t;

  class tint_scoreboard;
    logic [23:0] col_one, col_two, col_glow;
    logic [9:0]  bright;
    logic        replace;
    logic [2:0]  enable;
    rgba_t       pending[$];
    int          errors;
    int          checked;

    function new();
      col_one = 24'hFFFFFF; col_two = 24'hFFFFFF; col_glow = 24'hFFFFFF;
      bright = 10'd255; replace = 1'b0; enable = 3'd7;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(ltmc_pkg::cfg_idx_e idx, logic [23:0] val);
      case (idx)
        ltmc_pkg::CFG_COLOR_ONE:    col_one = val;
        ltmc_pkg::CFG_COLOR_TWO:    col_two = val;
        ltmc_pkg::CFG_GLOW:         col_glow = val;
        ltmc_pkg::CFG_BRIGHTNESS:   bright = val[9:0];
        ltmc_pkg::CFG_GLOW_REPLACE: replace = val[0];
        ltmc_pkg::CFG_MASK_ENABLE:  enable = val[2:0];
        default: ;
      endcase
    endfunction

    function longint unsigned rdiv(longint unsigned num, longint unsigned den);
      return (2 * num + den) / (2 * den);
    endfunction

    function void apply_tint(logic [23:0] rgb, longint unsigned lum, logic [7:0] m,
                             bit repl, ref longint unsigned px[3], ref logic [7:0] alpha);
      longint unsigned den, tmax, t;
      longint unsigned c[3];
      if (m == 0) return;
      den = 64'(100 * ((bright < 1) ? 1 : (bright > 1000) ? 1000 : bright));
      c[0] = 64'(rgb[23:16]); c[1] = 64'(rgb[15:8]); c[2] = 64'(rgb[7:0]);
      tmax = c[0];
      if (c[1] > tmax) tmax = c[1];
      if (c[2] > tmax) tmax = c[2];
      for (int i = 0; i < 3; i++) begin
        // clamp to full scale keeps the hue once the brightest channel saturates
        t = (tmax * lum > 255 * den) ? rdiv(c[i] * 255, tmax) : rdiv(c[i] * lum, den);
        px[i] = repl ? t : rdiv(t * m + px[i] * (255 - m), 255);
      end
      if (m > alpha) alpha = m;
    endfunction

    function void note_pixel(logic [7:0] r, g, b, a, m1, m2, mg);
      longint unsigned px[3];
      longint unsigned lum;
      logic [7:0] alpha;
      rgba_t res;
      px[0] = 64'(r); px[1] = 64'(g); px[2] = 64'(b); alpha = a;
      lum = 64'(30 * r + 59 * g + 11 * b);
      if (a != 0) begin
        if (enable[0]) apply_tint(col_one, lum, m1, 0, px, alpha);
        if (enable[1]) apply_tint(col_two, lum, m2, 0, px, alpha);
        if (enable[2]) apply_tint(col_glow, lum, mg, replace, px, alpha);
      end
      res.r = 8'(px[0]); res.g = 8'(px[1]); res.b = 8'(px[2]); res.a = alpha;
      pending.push_back(res);
    endfunction

    function void check_pixel(logic [7:0] r, g, b, a);
      rgba_t exp_px;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output beat r=%0d g=%0d b=%0d a=%0d", $time, r, g, b, a);
        errors++;
        return;
      end
      exp_px = pending.pop_front();
      checked++;
      if (r !== exp_px.r) begin
        $display("%0t: out_r expected %0d actual %0d", $time, exp_px.r, r); errors++;
      end
      if (g !== exp_px.g) begin
        $display("%0t: out_g expected %0d actual %0d", $time, exp_px.g, g); errors++;
      end
      if (b !== exp_px.b) begin
        $display("%0t: out_b expected %0d actual %0d", $time, exp_px.b, b); errors++;
      end
      if (a !== exp_px.a) begin
        $display("%0t: out_a expected %0d actual %0d", $time, exp_px.a, a); errors++;
      end
    endfunction
  endclass

  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] src_r_i = '0, src_g_i = '0, src_b_i = '0, src_a_i = '0;
  logic [7:0] mask_one_i = '0, mask_two_i = '0, mask_glow_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] out_r_o, out_g_o, out_b_o, out_a_o;

  tint_scoreboard sb = new();
  int idle_cycles = 0;
  bit out_stall_off = 0;
  int pixels_sent = 0;
  int settings_run = 0;

  always #5 clk_i = ~clk_i;

  luminance_tint_mask_compositor_unit dut (.*);

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // output side: random backpressure, check each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pixel(out_r_o, out_g_o, out_b_o, out_a_o);
  end

  initial begin
    int wait_n;
    @(posedge clk_i iff rst_ni);
    forever begin
      wait_n = out_stall_off ? 0 : gap_len();
      out_ready_i <= (wait_n == 0);
      repeat (wait_n > 0 ? wait_n : 1) @(posedge clk_i);
      if (wait_n > 0) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb_luminance_tint_mask_compositor_unit: FAIL");
      $finish;
    end
  end

  task automatic write_reg(ltmc_pkg::cfg_idx_e idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(logic [7:0] r, g, b, a, m1, m2, mg, bit gaps);
    int n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    src_r_i <= r; src_g_i <= g; src_b_i <= b; src_a_i <= a;
    mask_one_i <= m1; mask_two_i <= m2; mask_glow_i <= mg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(r, g, b, a, m1, m2, mg);
    pixels_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rnd_byte();
    int p = $urandom_range(0, 9);
    if (p == 0) return 8'd0;
    if (p == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_pixels(int count);
    for (int i = 0; i < count; i++)
      send_pixel(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(),
                 rnd_byte(), rnd_byte(), rnd_byte(), 1);
  endtask

  task automatic program_all(logic [23:0] c1, c2, cg, logic [9:0] br, bit rep,
                             logic [2:0] en);
    write_reg(ltmc_pkg::CFG_COLOR_ONE, c1);
    write_reg(ltmc_pkg::CFG_COLOR_TWO, c2);
    write_reg(ltmc_pkg::CFG_GLOW, cg);
    write_reg(ltmc_pkg::CFG_BRIGHTNESS, {14'd0, br});
    write_reg(ltmc_pkg::CFG_GLOW_REPLACE, {23'd0, rep});
    write_reg(ltmc_pkg::CFG_MASK_ENABLE, {21'd0, en});
    settings_run++;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats at reset settings
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0);
    send_pixel(8'd12, 8'd200, 8'd99, 8'd0, 8'd255, 8'd255, 8'd255, 0);   // transparent
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 0);       // zero masks
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 0);
    send_pixel(8'd128, 8'd64, 8'd32, 8'd10, 8'd1, 8'd128, 8'd200, 0);
    send_pixel(8'd170, 8'd85, 8'd85, 8'd255, 8'd0, 8'd0, 8'd255, 0);
    drain();
    program_all(24'hFF0000, 24'h00FF00, 24'h0000FF, 10'd1, 1'b1, 3'd7);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 0);  // saturating
    send_pixel(8'd1, 8'd0, 8'd0, 8'd5, 8'd100, 8'd100, 8'd100, 0);
    send_pixel(8'd90, 8'd30, 8'd200, 8'd20, 8'd0, 8'd0, 8'd77, 0);
    drain();
    program_all(24'h000000, 24'h808080, 24'h123456, 10'd0, 1'b0, 3'd0);  // all disabled
    send_pixel(8'd90, 8'd30, 8'd200, 8'd20, 8'd255, 8'd255, 8'd255, 0);
    drain();
    write_reg(ltmc_pkg::CFG_MASK_ENABLE, 24'd7);
    send_pixel(8'd90, 8'd30, 8'd200, 8'd20, 8'd255, 8'd9, 8'd255, 0);     // brightness zero
    drain();
    program_all(24'hFFFFFF, 24'h010203, 24'hFEDCBA, 10'd1023, 1'b1, 3'd5); // above range
    send_pixel(8'd255, 8'd255, 8'd255, 8'd200, 8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd40, 8'd250, 8'd7, 8'd3, 8'd60, 8'd60, 8'd0, 0);
    drain();
    program_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 10'd1000, 1'b0, 3'd7);
    random_pixels(200);
    drain();

    // random settings phases
    for (int ph = 0; ph < 8; ph++) begin
      program_all(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  24'($urandom_range(0, 24'hFFFFFF)),
                  10'((ph % 3 == 0) ? $urandom_range(1, 40) : $urandom_range(0, 1023)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      out_stall_off = (ph == 4);  // one stretch with the sink always ready
      random_pixels(200);
      drain();
    end
    out_stall_off = 0;

    $display("covered %0d pixels over %0d register settings, %0d beats checked",
             pixels_sent, settings_run, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_luminance_tint_mask_compositor_unit: PASS");
    else
      $display("tb_luminance_tint_mask_compositor_unit: FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
design/ltmc_pkg.sv
design/luminance_tint_mask_compositor_unit.sv
tb/tb_luminance_tint_mask_compositor_unit.sv
